// ===== hdl/nzrce_pkg.sv =====
// Package for the nonzero run coalescing encoder: result record type, codes,
// sequencer states and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nzrce_pkg;

  // Default parameter values for the top level.
  localparam int unsigned ADDR_BITS_DEF = 32;
  localparam int unsigned MAX_GAP_DEF   = 60;

  // Word index limits: the index saturates, and an image that reaches past
  // 2^32-1 bytes is too large.
  localparam logic [29:0] INDEX_MAX      = 30'h3FFF_FFFF;
  localparam logic [29:0] TL_FULL_INDEX  = 30'h1FFF_FFFF;
  localparam logic [29:0] TL_TAIL_INDEX  = 30'h2000_0000;
  localparam logic [3:0]  BYTES_PER_WORD = 4'd8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_STATUS  = 2'd2
  } nzrce_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_TOO_LARGE = 2'd2
  } nzrce_status_e;

  typedef enum logic [0:0] {
    CFG_GAP      = 1'b0,
    CFG_CAPACITY = 1'b1
  } nzrce_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CLOSE,
    S_OPEN,
    S_FILL,
    S_DATA,
    S_FINAL,
    S_TAIL,
    S_TAIL_HDR,
    S_TAIL_DAT,
    S_STATUS,
    S_DONE
  } nzrce_state_e;

  // One result beat as produced by the sequencer.
  typedef struct packed {
    nzrce_kind_e   kind;
    logic [31:0]   addr;
    logic [63:0]   data;
    logic [3:0]    nbytes;
    nzrce_status_e status;
    logic [31:0]   used;
  } nzrce_result_t;

  // Requests from the sequencer to the output stage.
  typedef struct packed {
    logic emit;
    logic flush;
  } nzrce_ctl_t;

  // Keeps the low nbytes bytes of a word.
  function automatic logic [63:0] tail_mask(input logic [3:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbytes) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/nzrce_addr_unit.sv =====
// Shared address adder and capacity compare of the encoder.
// Depends on nzrce_pkg for the default address width.
`timescale 1ns / 1ps
`default_nettype none

module nzrce_addr_unit import nzrce_pkg::*; #(
  parameter int unsigned AW = ADDR_BITS_DEF
) (
  input  wire logic [31:0] capacity_i,
  input  wire logic [AW:0] base_i,
  input  wire logic [3:0]  inc_i,
  output logic [AW+1:0]    sum_o,
  output logic             over_o
);

  localparam logic [AW-1:0] ADDR_MAX = '1;

  logic [AW-1:0] limit;

  // The usable buffer ends at the smaller of capacity and the address space.
  assign limit = (capacity_i > 32'(ADDR_MAX)) ? ADDR_MAX : capacity_i[AW-1:0];

  // End of the access, and whether it reaches past the buffer.
  assign sum_o  = (AW+2)'(base_i) + (AW+2)'(inc_i);
  assign over_o = sum_o > (AW+2)'(limit);

endmodule

`default_nettype wire

// ===== hdl/nzrce_out_stage.sv =====
// Result staging of the encoder: one pending beat plus the output register.
// The pending beat learns whether it is the last of its item before it leaves.
// Depends on nzrce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nzrce_out_stage import nzrce_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nzrce_ctl_t    ctl_i,
  input  wire nzrce_result_t res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         kind_o,
  output logic [31:0]        write_addr_o,
  output logic [63:0]        write_data_o,
  output logic [3:0]         write_bytes_o,
  output logic [1:0]         status_o,
  output logic [31:0]        used_bytes_o,
  output logic               last_o
);

  logic          pend_valid_q, pend_valid_d;
  nzrce_result_t pend_q;
  logic          out_valid_q, out_valid_d;
  nzrce_result_t out_q;
  logic          out_last_q;
  logic          out_free;
  logic          push_pend;

  // The output register frees up when empty or when its beat is taken.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign slot_free_o = !pend_valid_q || out_free;
  assign push_pend   = pend_valid_q && out_free && (ctl_i.emit || ctl_i.flush);

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (ctl_i.emit) begin
      pend_valid_d = 1'b1;
    end else if (push_pend) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (push_pend) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers. A flush means nothing follows in this item.
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      pend_q <= res_i;
    end
    if (push_pend) begin
      out_q      <= pend_q;
      out_last_q <= ctl_i.flush;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign write_addr_o  = out_q.addr;
  assign write_data_o  = out_q.data;
  assign write_bytes_o = out_q.nbytes;
  assign status_o      = out_q.status;
  assign used_bytes_o  = out_q.used;
  assign last_o        = out_last_q;

  // The sequencer only emits into a free slot.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> slot_free_o)
    else $error("result emitted while the pending slot was blocked");

  // A flush that finds room empties the pending beat.
  a_flush_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.flush && slot_free_o |=> !pend_valid_q)
    else $error("pending beat survived a flush");

  // A status beat always closes its item.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_STATUS |-> out_last_q)
    else $error("status beat without last");

endmodule

`default_nettype wire

// ===== hdl/nzrce_seq.sv =====
// Sequencer of the encoder: configuration registers, stream state and the
// state machine that steps one write at a time through the shared address
// unit. Depends on nzrce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nzrce_seq import nzrce_pkg::*; #(
  parameter int unsigned AW      = ADDR_BITS_DEF,
  parameter int unsigned MAX_GAP = MAX_GAP_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [63:0]   word_data_i,
  input  wire logic [3:0]    valid_bytes_i,
  input  wire logic          last_item_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output logic [AW:0]        au_base_o,
  output logic [3:0]         au_inc_o,
  input  wire logic [AW+1:0] au_sum_i,
  input  wire logic          au_over_i,
  output logic [31:0]        capacity_o,
  output nzrce_ctl_t         ctl_o,
  output nzrce_result_t      res_o,
  input  wire logic          slot_free_i
);

  nzrce_state_e  state_q, state_d;
  logic [29:0]   word_index_q, word_index_d;
  logic          run_open_q, run_open_d;
  logic [28:0]   run_start_q, run_start_d;
  logic [28:0]   last_nz_q, last_nz_d;
  logic [AW-1:0] run_header_q, run_header_d;
  logic [AW:0]   run_end_q, run_end_d;
  logic [AW-1:0] bytes_written_q, bytes_written_d;
  nzrce_status_e err_q, err_d;
  logic [5:0]    fill_cnt_q, fill_cnt_d;
  logic          final_phase_q, final_phase_d;

  logic [63:0]   data_q;
  logic [3:0]    vb_q;
  logic          fin_q;
  logic          full_q;
  logic [28:0]   cur_w_q;

  logic [5:0]    gap_q;
  logic [31:0]   cap_q;

  logic [5:0]    gap_eff;
  logic [29:0]   diff;
  logic [28:0]   run_len;
  logic [63:0]   tail_data;
  logic          in_take;

  assign cfg_ready_o = 1'b1;
  assign capacity_o  = cap_q;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = (state_q == S_IDLE) && in_valid_i;

  assign gap_eff   = (gap_q > 6'(MAX_GAP)) ? 6'(MAX_GAP) : gap_q;
  assign diff      = word_index_q - {1'b0, last_nz_q};
  assign run_len   = last_nz_q - run_start_q + 29'd1;
  assign tail_data = data_q & tail_mask(vb_q);

  // Next state, stream updates and the request to the address unit.
  always_comb begin
    state_d         = state_q;
    word_index_d    = word_index_q;
    run_open_d      = run_open_q;
    run_start_d     = run_start_q;
    last_nz_d       = last_nz_q;
    run_header_d    = run_header_q;
    run_end_d       = run_end_q;
    bytes_written_d = bytes_written_q;
    err_d           = err_q;
    fill_cnt_d      = fill_cnt_q;
    final_phase_d   = final_phase_q;
    ctl_o           = '0;
    res_o           = '0;
    au_base_o       = '0;
    au_inc_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end

      // Index bookkeeping and the decision how this word is handled.
      S_EVAL: begin
        state_d = S_FINAL;
        if (full_q) begin
          if (word_index_q >= TL_FULL_INDEX) begin
            err_d = ST_TOO_LARGE;
          end else if (err_q == ST_OK) begin
            if (run_open_q && diff > 30'(gap_eff)) begin
              state_d = S_CLOSE;
            end else if (data_q != 64'd0) begin
              if (run_open_q) begin
                fill_cnt_d = 6'(diff - 30'd1);
                state_d    = (diff == 30'd1) ? S_DATA : S_FILL;
              end else begin
                state_d = S_OPEN;
              end
            end
          end
          if (word_index_q != INDEX_MAX) begin
            word_index_d = word_index_q + 30'd1;
          end
        end
      end

      // Header of the open run into its reserved slot.
      S_CLOSE: begin
        au_base_o = {1'b0, run_header_q};
        au_inc_o  = BYTES_PER_WORD;
        if (au_over_i) begin
          err_d      = ST_OVERFLOW;
          run_open_d = 1'b0;
          state_d    = final_phase_q ? S_TAIL : S_FINAL;
        end else if (slot_free_i) begin
          ctl_o.emit      = 1'b1;
          res_o.kind      = KIND_HEADER;
          res_o.addr      = 32'(run_header_q);
          res_o.data      = {run_len, 3'b000, run_start_q, 3'b000};
          res_o.nbytes    = BYTES_PER_WORD;
          bytes_written_d = run_end_q[AW-1:0];
          run_open_d      = 1'b0;
          if (final_phase_q) begin
            state_d = S_TAIL;
          end else begin
            state_d = (data_q != 64'd0) ? S_OPEN : S_FINAL;
          end
        end
      end

      // Reserve the header slot of a new run.
      S_OPEN: begin
        au_base_o    = {1'b0, bytes_written_q};
        au_inc_o     = BYTES_PER_WORD;
        run_open_d   = 1'b1;
        run_start_d  = cur_w_q;
        run_header_d = bytes_written_q;
        run_end_d    = au_sum_i[AW:0];
        state_d      = S_DATA;
      end

      // Zero words between the last nonzero word and this one.
      S_FILL: begin
        au_base_o = run_end_q;
        au_inc_o  = BYTES_PER_WORD;
        if (au_over_i) begin
          err_d   = ST_OVERFLOW;
          state_d = S_FINAL;
        end else if (slot_free_i) begin
          ctl_o.emit   = 1'b1;
          res_o.kind   = KIND_PAYLOAD;
          res_o.addr   = 32'(run_end_q[AW-1:0]);
          res_o.nbytes = BYTES_PER_WORD;
          run_end_d    = au_sum_i[AW:0];
          fill_cnt_d   = fill_cnt_q - 6'd1;
          if (fill_cnt_q == 6'd1) begin
            state_d = S_DATA;
          end
        end
      end

      // The nonzero word itself.
      S_DATA: begin
        au_base_o = run_end_q;
        au_inc_o  = BYTES_PER_WORD;
        last_nz_d = cur_w_q;
        if (au_over_i) begin
          err_d   = ST_OVERFLOW;
          state_d = S_FINAL;
        end else if (slot_free_i) begin
          ctl_o.emit   = 1'b1;
          res_o.kind   = KIND_PAYLOAD;
          res_o.addr   = 32'(run_end_q[AW-1:0]);
          res_o.data   = data_q;
          res_o.nbytes = BYTES_PER_WORD;
          run_end_d    = au_sum_i[AW:0];
          state_d      = S_FINAL;
        end
      end

      // End of the item, or start of the end of image.
      S_FINAL: begin
        if (!fin_q) begin
          state_d = S_DONE;
        end else begin
          final_phase_d = 1'b1;
          state_d = (err_q == ST_OK && run_open_q) ? S_CLOSE : S_TAIL;
        end
      end

      // Partial last word: range check and room for a whole tail record.
      S_TAIL: begin
        au_base_o = {1'b0, bytes_written_q};
        au_inc_o  = BYTES_PER_WORD + vb_q;
        state_d   = S_STATUS;
        if (!full_q && vb_q != 4'd0) begin
          if (word_index_q >= TL_TAIL_INDEX) begin
            err_d = ST_TOO_LARGE;
          end else if (err_q == ST_OK && tail_data != 64'd0) begin
            if (au_over_i) begin
              err_d = ST_OVERFLOW;
            end else begin
              run_end_d = au_sum_i[AW:0];
              state_d   = S_TAIL_HDR;
            end
          end
        end
      end

      S_TAIL_HDR: begin
        au_base_o = {1'b0, bytes_written_q};
        au_inc_o  = BYTES_PER_WORD;
        if (slot_free_i) begin
          ctl_o.emit   = 1'b1;
          res_o.kind   = KIND_HEADER;
          res_o.addr   = 32'(bytes_written_q);
          res_o.data   = {28'd0, vb_q, word_index_q[28:0], 3'b000};
          res_o.nbytes = BYTES_PER_WORD;
          run_header_d = au_sum_i[AW-1:0];
          state_d      = S_TAIL_DAT;
        end
      end

      S_TAIL_DAT: begin
        if (slot_free_i) begin
          ctl_o.emit      = 1'b1;
          res_o.kind      = KIND_PAYLOAD;
          res_o.addr      = 32'(run_header_q);
          res_o.data      = tail_data;
          res_o.nbytes    = vb_q;
          bytes_written_d = run_end_q[AW-1:0];
          state_d         = S_TAIL_DAT == state_q ? S_STATUS : state_q;
        end
      end

      // Status beat, then the stream starts over.
      S_STATUS: begin
        if (slot_free_i) begin
          ctl_o.emit      = 1'b1;
          res_o.kind      = KIND_STATUS;
          res_o.status    = err_q;
          res_o.used      = (err_q == ST_OK) ? 32'(bytes_written_q) : 32'd0;
          word_index_d    = '0;
          run_open_d      = 1'b0;
          run_start_d     = '0;
          last_nz_d       = '0;
          run_header_d    = '0;
          run_end_d       = '0;
          bytes_written_d = '0;
          err_d           = ST_OK;
          final_phase_d   = 1'b0;
          state_d         = S_DONE;
        end
      end

      // Release the item's last beat with its last flag.
      S_DONE: begin
        ctl_o.flush = 1'b1;
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State machine and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      word_index_q    <= '0;
      run_open_q      <= 1'b0;
      run_start_q     <= '0;
      last_nz_q       <= '0;
      run_header_q    <= '0;
      run_end_q       <= '0;
      bytes_written_q <= '0;
      err_q           <= ST_OK;
      fill_cnt_q      <= '0;
      final_phase_q   <= 1'b0;
    end else begin
      state_q         <= state_d;
      word_index_q    <= word_index_d;
      run_open_q      <= run_open_d;
      run_start_q     <= run_start_d;
      last_nz_q       <= last_nz_d;
      run_header_q    <= run_header_d;
      run_end_q       <= run_end_d;
      bytes_written_q <= bytes_written_d;
      err_q           <= err_d;
      fill_cnt_q      <= fill_cnt_d;
      final_phase_q   <= final_phase_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
      cap_q <= 32'hFFFF_FFFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAP:      gap_q <= cfg_data_i[5:0];
        CFG_CAPACITY: cap_q <= cfg_data_i;
        default: begin
          gap_q <= gap_q;
        end
      endcase
    end
  end

  // Accepted item and the index of the word under work.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q <= word_data_i;
      vb_q   <= valid_bytes_i;
      fin_q  <= last_item_i;
      full_q <= !last_item_i || (valid_bytes_i >= BYTES_PER_WORD);
    end
    if (state_q == S_EVAL) begin
      cur_w_q <= word_index_q[28:0];
    end
  end

  // After an error only the status beat may leave.
  a_quiet_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit && res_o.kind != KIND_STATUS |-> err_q == ST_OK)
    else $error("write emitted after an error");

  // A fill pass always has at least one zero word left to write.
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> fill_cnt_q != 6'd0)
    else $error("fill pass entered with nothing to fill");

  // A run being closed ends at or after its start.
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLOSE && err_q == ST_OK |-> last_nz_q >= run_start_q)
    else $error("closing run ends before its start");

endmodule

`default_nettype wire

// ===== hdl/nonzero_run_coalescing_encoder.sv =====
// Nonzero run coalescing encoder, top level; uses nzrce_pkg, nzrce_seq,
// nzrce_addr_unit and nzrce_out_stage. An item is taken only while the sequencer
// is idle, so a new item waits until the last one is through. A gap fill writes
// one result per zero word, and output stalls hold the sequencer. Each beat
// waits in the pending slot before it reaches the output register. Reset
// (async, low) clears the stream; the gap register resets to 0 and capacity
// to its maximum.
`timescale 1ns / 1ps
`default_nettype none

module nonzero_run_coalescing_encoder import nzrce_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF,
  parameter int unsigned MAX_GAP   = MAX_GAP_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] word_data_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic        last_item_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      write_addr_o,
  output logic [63:0]      write_data_o,
  output logic [3:0]       write_bytes_o,
  output logic [1:0]       status_o,
  output logic [31:0]      used_bytes_o,
  output logic             last_o
);

  logic [ADDR_BITS:0]   au_base;
  logic [3:0]           au_inc;
  logic [ADDR_BITS+1:0] au_sum;
  logic                 au_over;
  logic [31:0]          capacity;
  nzrce_ctl_t           ctl;
  nzrce_result_t        res;
  logic                 slot_free;

  // Sequencer with configuration and stream state.
  nzrce_seq #(
    .AW      (ADDR_BITS),
    .MAX_GAP (MAX_GAP)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_data_i   (word_data_i),
    .valid_bytes_i (valid_bytes_i),
    .last_item_i   (last_item_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .au_base_o     (au_base),
    .au_inc_o      (au_inc),
    .au_sum_i      (au_sum),
    .au_over_i     (au_over),
    .capacity_o    (capacity),
    .ctl_o         (ctl),
    .res_o         (res),
    .slot_free_i   (slot_free)
  );

  // Shared address adder and capacity check.
  nzrce_addr_unit #(
    .AW (ADDR_BITS)
  ) u_addr_unit (
    .capacity_i (capacity),
    .base_i     (au_base),
    .inc_i      (au_inc),
    .sum_o      (au_sum),
    .over_o     (au_over)
  );

  // Pending beat and output register.
  nzrce_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .res_i         (res),
    .slot_free_o   (slot_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .write_addr_o  (write_addr_o),
    .write_data_o  (write_data_o),
    .write_bytes_o (write_bytes_o),
    .status_o      (status_o),
    .used_bytes_o  (used_bytes_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for nonzero_run_coalescing_encoder. Depends on nzrce_pkg
// and the encoder RTL. Images of words go in on one port, record writes and
// status beats are predicted and compared, and the registers change between images.
`timescale 1ns / 1ps

import nzrce_pkg::*;

// One write or status beat as seen on the output port.
typedef struct packed {
  nzrce_kind_e   kind;
  logic [31:0]   addr;
  logic [63:0]   data;
  logic [3:0]    nbytes;
  nzrce_status_e status;
  logic [31:0]   used;
  logic          last;
} rec_beat_t;

// Predicts the record writes of each accepted word and holds them until the
// matching beats come out of the encoder.
class record_stream_board;
  bit [5:0]        gap_reg = '0;
  bit [31:0]       cap_reg = 32'hFFFF_FFFF;
  longint unsigned word_idx, run_first, last_nz, hdr_addr, written;
  bit              run_open;
  nzrce_status_e   code = ST_OK;
  rec_beat_t       owed[$];
  int              errors, images, overflow_images, items, beats;

  function void clear_image();
    word_idx = 0;
    run_open = 1'b0;
    run_first = 0;
    last_nz = 0;
    hdr_addr = 0;
    written = 0;
    code = ST_OK;
  endfunction

  function void set_reg(nzrce_cfg_e idx, logic [31:0] val);
    if (idx == CFG_GAP) begin
      gap_reg = val[5:0];
    end else begin
      cap_reg = val;
    end
  endfunction

  function int pending();
    return owed.size();
  endfunction

  // Prints one line per mismatch and counts it.
  task report(string what);
    errors++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  function void push(nzrce_kind_e k, longint unsigned addr, logic [63:0] data,
                     int unsigned nb, nzrce_status_e st, longint unsigned used);
    rec_beat_t b;
    b.kind   = k;
    b.addr   = 32'(addr);
    b.data   = data;
    b.nbytes = 4'(nb);
    b.status = st;
    b.used   = 32'(used);
    b.last   = 1'b0;
    owed.push_back(b);
  endfunction

  // A write that would reach past capacity is dropped and flags overflow.
  function void store(nzrce_kind_e k, longint unsigned addr, logic [63:0] data,
                      int unsigned nb);
    if (code != ST_OK) return;
    if (addr + nb > cap_reg) begin
      code = ST_OVERFLOW;
      return;
    end
    push(k, addr, data, nb, ST_OK, 0);
  endfunction

  function longint unsigned slot_addr(longint unsigned k);
    return hdr_addr + 8 + (k - run_first) * 8;
  endfunction

  // Writes the header into the slot reserved when the run opened.
  function void close_run();
    longint unsigned len;
    if (!run_open) return;
    len = (last_nz - run_first + 1) * 8;
    store(KIND_HEADER, hdr_addr,
          ((run_first * 8) & 64'hFFFF_FFFF) | ((len & 64'hFFFF_FFFF) << 32), 8);
    written = hdr_addr + 8 + len;
    run_open = 1'b0;
  endfunction

  function void add_word(longint unsigned w, logic [63:0] data, longint unsigned gap);
    longint unsigned k;
    if (run_open && w - last_nz > gap) close_run();
    if (data == 64'h0) return;
    if (run_open) begin
      // The zeros between two nonzero words of one run are written too.
      for (k = last_nz + 1; k < w; k++) begin
        store(KIND_PAYLOAD, slot_addr(k), 64'h0, 8);
      end
    end else begin
      run_open = 1'b1;
      run_first = w;
      hdr_addr = written;
    end
    last_nz = w;
    store(KIND_PAYLOAD, slot_addr(w), data, 8);
  endfunction

  function void take_item(logic [63:0] data, logic [3:0] vb, logic fin);
    longint unsigned w, gap;
    logic [63:0]     tail;
    bit              full;
    int              n0;
    items++;
    n0 = owed.size();
    w = word_idx;
    full = !fin || vb >= 8;
    gap = (gap_reg > MAX_GAP_DEF) ? MAX_GAP_DEF : gap_reg;

    if (full) begin
      if (w * 8 + 8 > 64'hFFFF_FFFF) code = ST_TOO_LARGE;
      if (code == ST_OK) add_word(w, data, gap);
      if (w < INDEX_MAX) word_idx = w + 1;
    end

    if (fin) begin
      if (code == ST_OK) close_run();
      // A partial last word becomes its own record, checked whole against capacity.
      if (!full && vb != 0) begin
        tail = '0;
        for (int i = 0; i < vb; i++) begin
          tail[i*8 +: 8] = data[i*8 +: 8];
        end
        if (w * 8 + vb > 64'hFFFF_FFFF) begin
          code = ST_TOO_LARGE;
        end else if (code == ST_OK && tail != 64'h0) begin
          if (written + 8 + vb > cap_reg) begin
            code = ST_OVERFLOW;
          end else begin
            store(KIND_HEADER, written, ((w * 8) & 64'hFFFF_FFFF) | (64'(vb) << 32), 8);
            store(KIND_PAYLOAD, written + 8, tail, vb);
            written += 8 + vb;
          end
        end
      end
      push(KIND_STATUS, 0, 64'h0, 0, code, (code == ST_OK) ? written : 0);
      images++;
      if (code == ST_OVERFLOW) overflow_images++;
      clear_image();
    end

    if (owed.size() > n0) owed[owed.size() - 1].last = 1'b1;
  endfunction

  task match_beat(rec_beat_t got);
    rec_beat_t want;
    string     diffs;
    beats++;
    if (owed.size() == 0) begin
      report($sformatf("beat %0d arrived with nothing owed: kind %0d addr %0h data %0h",
                       beats, got.kind, got.addr, got.data));
      return;
    end
    want = owed.pop_front();
    diffs = "";
    if (got.kind !== want.kind)
      diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
    if (got.addr !== want.addr)
      diffs = {diffs, $sformatf(" addr %0h/%0h", got.addr, want.addr)};
    if (got.data !== want.data)
      diffs = {diffs, $sformatf(" data %0h/%0h", got.data, want.data)};
    if (got.nbytes !== want.nbytes)
      diffs = {diffs, $sformatf(" bytes %0d/%0d", got.nbytes, want.nbytes)};
    if (got.status !== want.status)
      diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
    if (got.used !== want.used)
      diffs = {diffs, $sformatf(" used %0d/%0d", got.used, want.used)};
    if (got.last !== want.last)
      diffs = {diffs, $sformatf(" last %0d/%0d", got.last, want.last)};
    if (diffs != "") report($sformatf("beat %0d (got/want):%s", beats, diffs));
  endtask
endclass

module tb_top;

  localparam int RANDOM_ITEMS = 230;
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] word_data_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        last_item_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] write_addr_o;
  logic [63:0] write_data_o;
  logic [3:0]  write_bytes_o;
  logic [1:0]  status_o;
  logic [31:0] used_bytes_o;
  logic        last_o;

  record_stream_board sb;
  rec_beat_t          got_beat;
  int                 items_sent;
  bit                 quiet_in;
  logic [5:0]         gap_now;
  int                 hold_left;
  int                 stall_pick;

  nonzero_run_coalescing_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_data_i   (word_data_i),
    .valid_bytes_i (valid_bytes_i),
    .last_item_i   (last_item_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .write_addr_o  (write_addr_o),
    .write_data_o  (write_data_o),
    .write_bytes_o (write_bytes_o),
    .status_o      (status_o),
    .used_bytes_o  (used_bytes_o),
    .last_o        (last_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung run ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d beats still owed", CYCLE_LIMIT,
             sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output stall: short stalls, a few long ones, and quiet stretches.
  initial begin
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        stall_pick = $urandom_range(99);
        if (stall_pick < 8) begin
          out_stall_i <= 1'b0;
          hold_left = $urandom_range(100, 250);
        end else if (stall_pick < 38) begin
          out_stall_i <= 1'b1;
          hold_left = (stall_pick < 34) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end else begin
          out_stall_i <= 1'b0;
          hold_left = $urandom_range(0, 6);
        end
      end
    end
  end

  // Every accepted output beat is checked against the oldest owed beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat.kind   = nzrce_kind_e'(kind_o);
      got_beat.addr   = write_addr_o;
      got_beat.data   = write_data_o;
      got_beat.nbytes = write_bytes_o;
      got_beat.status = nzrce_status_e'(status_o);
      got_beat.used   = used_bytes_o;
      got_beat.last   = last_o;
      sb.match_beat(got_beat);
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (quiet_in || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 60) return {$urandom, $urandom};
    if (r < 75) return 64'h1 << $urandom_range(0, 63);
    if (r < 85) return '1;
    if (r < 95) return {56'h0, 8'($urandom_range(1, 255))};
    return {$urandom, $urandom} | 64'h1;
  endfunction

  // valid_bytes is ignored on words that do not end the image.
  function automatic logic [3:0] pick_vb();
    return ($urandom_range(99) < 85) ? 4'd8 : 4'($urandom_range(0, 15));
  endfunction

  // Presents one word and holds it until the encoder takes it.
  task automatic send_item(logic [63:0] data, logic [3:0] vb, logic fin);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    word_data_i   <= data;
    valid_bytes_i <= vb;
    last_item_i   <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_item(data, vb, fin);
    items_sent++;
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so that writes can follow back to back.
  task automatic write_reg(nzrce_cfg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // Registers only change once the encoder has gone idle.
  task automatic configure(logic [5:0] gap, logic [31:0] cap);
    in_valid_i <= 1'b0;
    drain();
    write_reg(CFG_GAP, {26'($urandom), gap});
    write_reg(CFG_CAPACITY, cap);
    cfg_valid_i <= 1'b0;
    gap_now = gap;
  endtask

  // One random image: nonzero words with zero runs placed around the gap.
  task automatic send_random_image();
    int          target, count, z, r, eff;
    logic [63:0] d;
    logic [3:0]  vb;
    eff = (gap_now > MAX_GAP_DEF) ? MAX_GAP_DEF : gap_now;
    target = ($urandom_range(99) < 85) ? $urandom_range(1, 14) : $urandom_range(20, 70);
    quiet_in = ($urandom_range(7) == 0);
    count = 0;
    while (count < target - 1) begin
      r = $urandom_range(99);
      if (r < 45) begin
        z = 0;
      end else if (r < 72) begin
        z = $urandom_range(1, 3);
      end else if (r < 88) begin
        z = eff - 1 + $urandom_range(0, 1);
        if (z < 0) z = 0;
      end else begin
        z = $urandom_range(0, eff + 2);
      end
      repeat (z) begin
        send_item(64'h0, pick_vb(), 1'b0);
        count++;
      end
      send_item(pick_word(), pick_vb(), 1'b0);
      count++;
    end

    // The last word: full, partial, empty, or partial with only ignored bytes set.
    r = $urandom_range(99);
    d = {$urandom, $urandom};
    if (r < 35) begin
      vb = 4'($urandom_range(8, 15));
      d = ($urandom_range(4) == 0) ? 64'h0 : pick_word();
    end else if (r < 75) begin
      vb = 4'($urandom_range(1, 7));
    end else if (r < 85) begin
      vb = 4'd0;
    end else begin
      vb = 4'($urandom_range(1, 7));
      for (int i = 0; i < vb; i++) d[i*8 +: 8] = 8'h00;
    end
    send_item(d, vb, 1'b1);
  endtask

  initial begin
    int r;
    logic [5:0]  gap_sel;
    logic [31:0] cap_sel;
    sb = new;
    items_sent = 0;
    quiet_in = 1'b0;
    gap_now = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Runs joined across a gap fill, a run closed by a long gap, and a partial
    // tail whose ignored high bytes are set.
    configure(6'd2, 32'hFFFF_FFFF);
    send_item('1, 4'd8, 1'b0);
    send_item(64'h0, 4'd8, 1'b0);
    send_item(64'h1, 4'd8, 1'b0);
    send_item(64'h0, 4'd8, 1'b0);
    send_item(64'h0, 4'd8, 1'b0);
    send_item(64'h0, 4'd8, 1'b0);
    send_item(64'h8000_0000_0000_0000, 4'd8, 1'b0);
    send_item(64'hAB00_0000_00C0_FFEE, 4'd3, 1'b1);

    // Gap zero: neighbors make separate records; odd valid_bytes on inner
    // words; a last item with no tail bytes.
    configure(6'd0, 32'hFFFF_FFFF);
    send_item(64'h5, 4'd4, 1'b0);
    send_item(64'h7, 4'd0, 1'b0);
    send_item(64'hFF, 4'd0, 1'b1);
    send_item(64'h1234_5678_9ABC_DEF0, 4'd8, 1'b1);
    send_item(64'h0, 4'd15, 1'b1);
    send_item(64'hFFFF_FF00_0000_0000, 4'd5, 1'b1);
    send_item('1, 4'd7, 1'b1);

    // Zero capacity: the first write already overflows; gap above its range.
    configure(6'd63, 32'd0);
    send_item(64'h42, 4'd8, 1'b0);
    send_item(64'h0, 4'd8, 1'b1);

    // The tail record does not fit into the capacity left after the first run.
    configure(6'd1, 32'd20);
    send_item(64'h99, 4'd8, 1'b0);
    send_item(64'h0000_00AA_BBCC_DDEE, 4'd5, 1'b1);

    // Random images under changing gap and capacity settings.
    while (items_sent < 19 + RANDOM_ITEMS) begin
      if (sb.images == 8 || $urandom_range(99) < 60) begin
        r = $urandom_range(99);
        if (r < 15) gap_sel = 6'd0;
        else if (r < 25) gap_sel = 6'(MAX_GAP_DEF);
        else if (r < 35) gap_sel = 6'd63;
        else if (r < 45) gap_sel = 6'($urandom_range(0, 63));
        else gap_sel = 6'($urandom_range(1, 6));
        r = $urandom_range(99);
        if (r < 75) cap_sel = 32'hFFFF_FFFF;
        else if (r < 85) cap_sel = $urandom_range(0, 200);
        else if (r < 90) cap_sel = 32'd0;
        else cap_sel = $urandom_range(200, 2000);
        configure(gap_sel, cap_sel);
      end
      send_random_image();
    end

    in_valid_i <= 1'b0;
    drain();
    if (sb.pending() != 0) sb.report($sformatf("%0d beats never arrived", sb.pending()));

    $display("Covered %0d images of %0d words in all, %0d of them overflowing capacity,",
             sb.images, sb.items, sb.overflow_images);
    $display("and compared %0d write and status beats under gap and capacity changes.",
             sb.beats);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
